@@ src/imu_acc_pkg.sv @@
// ============================================================================
// imu_acc_pkg: shared types and constants of the sensor burst-read accumulator
// Holds command and bus action codes, frame constants and the operation record
// that travels from the sequencing front end to the accumulating back end.
// ============================================================================
package imu_acc_pkg;

  localparam logic [1:0] CMD_TRIGGER = 2'd0;
  localparam logic [1:0] CMD_BUS_DONE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] DEV_ADDR_RST = 8'd208;
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT = 8'h01;
  localparam logic [7:0] DATA_REG = 8'h3B;
  localparam logic [3:0] FRAME_LEN = 4'd14;
  localparam int unsigned NUM_CH = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_TX      = 3'd2,
    ACT_RSTART  = 3'd3,
    ACT_RX      = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_NACK    = 3'd6,
    ACT_RELEASE = 3'd7
  } bus_action_e;

  typedef struct packed {
    bus_action_e action;
    logic [7:0]  tx_byte;
    logic        wr_en;
    logic [3:0]  wr_pos;
    logic [7:0]  wr_byte;
    logic        take;
    logic        clear;
  } op_t;

endpackage

@@ src/i2c_imu_burst_read_accumulator_core.sv @@
// ============================================================================
// i2c_imu_burst_read_accumulator_core: sensor burst-read sequencer top level
// Drives an I2C master through a 14-byte register burst read and sums frames.
// ============================================================================
// Usage:
// Each input beat on s_axis carries one command (tuser) with bus flags and the
// received byte (tdata). Every input beat yields exactly one output beat on
// m_axis: the bus action to perform and its byte, a frame-done flag, the seven
// channel sums and the two frame counters.
// The user loads the device address register through cfg_we_i and cfg_wdata_i
// only while no beats are in flight; the block itself does not enforce this.
// From input beat to output beat, the front end steps the sequence and queues
// an operation, and the back end executes it into the output register. One
// beat per cycle is sustained in both directions while m_axis_tready stays high;
// a frame completion does its seven 32-bit adds at once in the back end.
// When m_axis_tready is low the output register holds, the two-entry queue
// fills and s_axis_tready drops once it is full.
// Reset clears the sequence state, sums and counters, and restores the device
// address to its default. No clearing pass is needed.
// ============================================================================
module i2c_imu_burst_read_accumulator_core import imu_acc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: bus_free, nack_seen, bus_collision, write_collision, read_overflow,
  // rx_byte[7:0], zero fill.
  input  logic [15:0]  s_axis_tdata,
  // tuser: command[1:0].
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: tx_byte, sum_accel_x, sum_accel_y, sum_accel_z, sum_temperature,
  // sum_gyro_x, sum_gyro_y, sum_gyro_z, accumulated_frames, total_frames.
  output logic [263:0] m_axis_tdata,
  // tuser: bus_action[2:0], frame_done.
  output logic [3:0]   m_axis_tuser
);

  logic        push_valid;
  logic        push_ready;
  op_t         push_op;
  logic        pop_valid;
  logic        pop_ready;
  op_t         pop_op;
  logic        in_err;
  bus_action_e out_action;
  logic [7:0]  out_tx_byte;
  logic        out_done;
  logic [31:0] out_sums [NUM_CH];
  logic [15:0] out_ready_count;
  logic [15:0] out_frame_count;

  assign in_err = |s_axis_tdata[4:1];

  imu_acc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_cmd_i      (s_axis_tuser),
    .in_bus_free_i (s_axis_tdata[0]),
    .in_err_i      (in_err),
    .in_rx_byte_i  (s_axis_tdata[12:5]),
    .push_ready_i  (push_ready),
    .in_ready_o    (s_axis_tready),
    .push_valid_o  (push_valid),
    .push_op_o     (push_op)
  );

  imu_acc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_op_i    (push_op),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  imu_acc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_op_i          (pop_op),
    .pop_ready_o       (pop_ready),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_action_o      (out_action),
    .out_tx_byte_o     (out_tx_byte),
    .out_done_o        (out_done),
    .out_sums_o        (out_sums),
    .out_ready_count_o (out_ready_count),
    .out_frame_count_o (out_frame_count)
  );

  assign m_axis_tuser = {out_done, out_action};
  assign m_axis_tdata = {out_frame_count, out_ready_count,
                         out_sums[6], out_sums[5], out_sums[4], out_sums[3],
                         out_sums[2], out_sums[1], out_sums[0], out_tx_byte};

endmodule

@@ src/imu_acc_front.sv @@
// ============================================================================
// imu_acc_front: bus sequencing front end
// Accepts command beats, steps the burst-read sequence and emits one operation
// record per beat for the back end.
// ============================================================================
module imu_acc_front import imu_acc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  input  logic       in_bus_free_i,
  input  logic       in_err_i,
  input  logic [7:0] in_rx_byte_i,
  input  logic       push_ready_i,
  output logic       in_ready_o,
  output logic       push_valid_o,
  output op_t        push_op_o
);

  localparam logic [2:0] PH_WR_ADDR = 3'd0;
  localparam logic [2:0] PH_REG = 3'd1;
  localparam logic [2:0] PH_RSTART = 3'd2;
  localparam logic [2:0] PH_RD_ADDR = 3'd3;
  localparam logic [2:0] PH_FIRST_RX = 3'd4;
  localparam logic [2:0] PH_BYTE = 3'd5;
  localparam logic [2:0] PH_NEXT_RX = 3'd6;
  localparam logic [2:0] PH_FINISH = 3'd7;

  logic [7:0] dev_addr_q;
  logic [2:0] phase_q, phase_d;
  logic       active_q, active_d;
  logic [3:0] pos_q, pos_d;
  logic [3:0] pos_inc;
  logic       fire;
  op_t        op;

  assign in_ready_o = push_ready_i;
  assign fire = in_valid_i & push_ready_i;
  assign pos_inc = pos_q + 4'd1;
  assign push_valid_o = fire;
  assign push_op_o = op;

  always_comb begin
    phase_d = phase_q;
    active_d = active_q;
    pos_d = pos_q;
    op = '0;
    op.action = ACT_NONE;
    if (fire) begin
      case (in_cmd_i)
        CMD_TRIGGER: begin
          if (!active_q && in_bus_free_i) begin
            active_d = 1'b1;
            phase_d = PH_WR_ADDR;
            op.action = ACT_START;
          end
        end
        CMD_BUS_DONE: begin
          if (active_q) begin
            if (in_err_i) begin
              active_d = 1'b0;
              op.action = ACT_RELEASE;
            end else begin
              case (phase_q)
                PH_WR_ADDR: begin
                  op.action = ACT_TX;
                  op.tx_byte = dev_addr_q & ADDR_WR_MASK;
                  phase_d = PH_REG;
                end
                PH_REG: begin
                  op.action = ACT_TX;
                  op.tx_byte = DATA_REG;
                  phase_d = PH_RSTART;
                end
                PH_RSTART: begin
                  op.action = ACT_RSTART;
                  phase_d = PH_RD_ADDR;
                end
                PH_RD_ADDR: begin
                  op.action = ACT_TX;
                  op.tx_byte = dev_addr_q | ADDR_RD_BIT;
                  phase_d = PH_FIRST_RX;
                end
                PH_FIRST_RX: begin
                  pos_d = 4'd0;
                  op.action = ACT_RX;
                  phase_d = PH_BYTE;
                end
                PH_BYTE: begin
                  op.wr_en = (pos_q < FRAME_LEN);
                  op.wr_pos = pos_q;
                  op.wr_byte = in_rx_byte_i;
                  pos_d = pos_inc;
                  if (pos_inc < FRAME_LEN) begin
                    op.action = ACT_ACK;
                    phase_d = PH_NEXT_RX;
                  end else begin
                    op.action = ACT_NACK;
                    phase_d = PH_FINISH;
                  end
                end
                PH_NEXT_RX: begin
                  op.action = ACT_RX;
                  phase_d = PH_BYTE;
                end
                default: begin
                  active_d = 1'b0;
                  op.action = ACT_RELEASE;
                  op.take = 1'b1;
                end
              endcase
            end
          end
        end
        CMD_CLEAR: begin
          op.clear = 1'b1;
        end
        default: begin
          op.action = ACT_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
      phase_q <= PH_WR_ADDR;
      active_q <= 1'b0;
      pos_q <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      active_q <= active_d;
      pos_q <= pos_d;
    end
  end

endmodule

@@ src/imu_acc_queue.sv @@
// ============================================================================
// imu_acc_queue: operation queue
// A two-entry first-in first-out buffer between front end and back end.
// ============================================================================
module imu_acc_queue import imu_acc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  op_t  push_op_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  op_t        mem_q [QUEUE_DEPTH];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'(QUEUE_DEPTH));
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign push = push_valid_i & push_ready_o;
  assign pop = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ src/imu_acc_back.sv @@
// ============================================================================
// imu_acc_back: frame store, accumulator and result register
// Executes queued operations: stores received bytes, assembles and sums frames
// and presents one result beat per operation.
// ============================================================================
module imu_acc_back import imu_acc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  input  op_t         pop_op_i,
  output logic        pop_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bus_action_e out_action_o,
  output logic [7:0]  out_tx_byte_o,
  output logic        out_done_o,
  output logic [31:0] out_sums_o [NUM_CH],
  output logic [15:0] out_ready_count_o,
  output logic [15:0] out_frame_count_o
);

  logic [7:0]  frame_q [FRAME_LEN];
  logic [31:0] sums_q [NUM_CH];
  logic [31:0] sums_d [NUM_CH];
  logic [31:0] words [NUM_CH];
  logic [15:0] ready_count_q, ready_count_d;
  logic [15:0] frame_count_q, frame_count_d;
  logic        valid_q;
  bus_action_e action_q;
  logic [7:0]  tx_q;
  logic        done_q;
  logic        pop;

  function automatic logic [31:0] word_ext(input logic [7:0] hi, input logic [7:0] lo,
                                           input logic neg);
    logic [15:0] w;
    begin
      w = {hi, lo};
      if (neg) begin
        w = 16'd0 - w;
      end
      word_ext = {{16{w[15]}}, w};
    end
  endfunction

  assign pop_ready_o = !valid_q || out_ready_i;
  assign pop = pop_valid_i & pop_ready_o;

  assign words[0] = word_ext(frame_q[2], frame_q[3], 1'b1);
  assign words[1] = word_ext(frame_q[0], frame_q[1], 1'b1);
  assign words[2] = word_ext(frame_q[4], frame_q[5], 1'b1);
  assign words[3] = word_ext(frame_q[6], frame_q[7], 1'b0);
  assign words[4] = word_ext(frame_q[10], frame_q[11], 1'b1);
  assign words[5] = word_ext(frame_q[8], frame_q[9], 1'b1);
  assign words[6] = word_ext(frame_q[12], frame_q[13], 1'b1);

  always_comb begin
    ready_count_d = ready_count_q;
    frame_count_d = frame_count_q;
    for (int i = 0; i < NUM_CH; i++) begin
      sums_d[i] = sums_q[i];
    end
    if (pop_op_i.take) begin
      frame_count_d = frame_count_q + 16'd1;
      ready_count_d = ready_count_q + 16'd1;
      for (int i = 0; i < NUM_CH; i++) begin
        sums_d[i] = (ready_count_q == 16'd0) ? words[i] : sums_q[i] + words[i];
      end
    end else if (pop_op_i.clear) begin
      ready_count_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && pop_op_i.wr_en) begin
      frame_q[pop_op_i.wr_pos] <= pop_op_i.wr_byte;
    end
    if (pop) begin
      action_q <= pop_op_i.action;
      tx_q <= pop_op_i.tx_byte;
      done_q <= pop_op_i.take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ready_count_q <= 16'd0;
      frame_count_q <= 16'd0;
      for (int i = 0; i < NUM_CH; i++) begin
        sums_q[i] <= 32'd0;
      end
    end else begin
      if (pop) begin
        valid_q <= 1'b1;
        ready_count_q <= ready_count_d;
        frame_count_q <= frame_count_d;
        for (int i = 0; i < NUM_CH; i++) begin
          sums_q[i] <= sums_d[i];
        end
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_action_o = action_q;
  assign out_tx_byte_o = tx_q;
  assign out_done_o = done_q;
  assign out_sums_o = sums_q;
  assign out_ready_count_o = ready_count_q;
  assign out_frame_count_o = frame_count_q;

`ifndef SYNTHESIS
  a_done_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && done_q) |-> (action_q == ACT_RELEASE))
    else $error("Frame completion without bus release.");

  a_take_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_op_i.take) |=> (frame_count_q == $past(frame_count_q) + 16'd1))
    else $error("Frame counter did not advance on a completed frame.");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_op_i.clear) |=> (ready_count_q == 16'd0))
    else $error("Accumulation count not cleared.");

  a_stall_holds_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> $stable(sums_q[0]) && $stable(ready_count_q))
    else $error("Sums changed while a result beat was stalled.");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top: stream-level test of the sensor burst-read sequencer and accumulator
// Walks a short table of trigger, bus event and clear beats, then runs random
// burst-read sessions with random frame bytes, injected bus errors and noise
// beats across several device address settings. Every output beat is compared
// field by field with an in-line prediction of the sequencer and the sums.
// ============================================================================
module tb_top;
  import imu_acc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BEATS = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [4:0] F_NONE = 5'b00000;
  localparam logic [4:0] F_FREE = 5'b00001;
  localparam logic [4:0] F_NACK = 5'b00010;
  localparam logic [4:0] F_BCOL = 5'b00100;
  localparam logic [4:0] F_WCOL = 5'b01000;
  localparam logic [4:0] F_OVF  = 5'b10000;
  localparam logic [4:0] F_ERR  = 5'b11110;

  localparam logic [2:0] PH_ADDR_W = 3'd0;
  localparam logic [2:0] PH_REG    = 3'd1;
  localparam logic [2:0] PH_RSTART = 3'd2;
  localparam logic [2:0] PH_ADDR_R = 3'd3;
  localparam logic [2:0] PH_RX0    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_RXN    = 3'd6;
  localparam logic [2:0] PH_LAST   = 3'd7;

  typedef struct packed {
    bus_action_e     action;
    logic [7:0]      tx;
    logic            done;
    logic [6:0][31:0] sums;
    logic [15:0]     acc;
    logic [15:0]     tot;
  } bus_result_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  fl;
    logic [7:0]  rx;
    logic        chk;
    bus_action_e act;
    logic [7:0]  tx;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [7:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [263:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  i2c_imu_burst_read_accumulator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Predicted block state.
  logic [7:0]       dev_addr = DEV_ADDR_RST;
  logic [2:0]       seq_ph = PH_ADDR_W;
  logic             in_session = 1'b0;
  logic [3:0]       byte_pos = '0;
  logic [7:0]       frame_buf [14];
  logic [6:0][31:0] ch_sum = '0;
  logic [15:0]      sum_frames = '0;
  logic [15:0]      read_frames = '0;

  bus_result_t due_outputs [$];
  bus_result_t pred_r;
  bus_result_t want_r;
  bus_result_t got_r;

  logic         pin_on;
  bus_action_e  pin_act;
  logic [7:0]   pin_tx;
  logic         calm = 1'b0;
  int           stall_left = 0;
  int unsigned  cycles = 0;
  int unsigned  n_err = 0;
  int unsigned  n_beats_in = 0;
  int unsigned  n_beats_out = 0;
  int unsigned  n_frames = 0;
  int unsigned  n_aborts = 0;
  int unsigned  n_cfg = 0;
  stim_row_t    dir_tab [26];

  function automatic logic [31:0] widen(logic [15:0] x, bit neg);
    logic [15:0] y;
    y = neg ? (~x + 16'd1) : x;
    return {{16{y[15]}}, y};
  endfunction

  function automatic bus_result_t predict_bus_step(logic [1:0] cmd, logic [4:0] fl,
                                                   logic [7:0] rx);
    bus_result_t r;
    logic [15:0] w [7];
    logic [31:0] v [7];
    r = '0;
    r.action = ACT_NONE;
    case (cmd)
      CMD_TRIGGER: begin
        if (!in_session && fl[0]) begin
          in_session = 1'b1;
          seq_ph = PH_ADDR_W;
          r.action = ACT_START;
        end
      end
      CMD_BUS_DONE: begin
        if (in_session) begin
          if (|fl[4:1]) begin
            in_session = 1'b0;
            r.action = ACT_RELEASE;
          end else begin
            case (seq_ph)
              PH_ADDR_W: begin
                r.tx = dev_addr & ADDR_WR_MASK;
                r.action = ACT_TX;
                seq_ph = PH_REG;
              end
              PH_REG: begin
                r.tx = DATA_REG;
                r.action = ACT_TX;
                seq_ph = PH_RSTART;
              end
              PH_RSTART: begin
                r.action = ACT_RSTART;
                seq_ph = PH_ADDR_R;
              end
              PH_ADDR_R: begin
                r.tx = dev_addr | ADDR_RD_BIT;
                r.action = ACT_TX;
                seq_ph = PH_RX0;
              end
              PH_RX0: begin
                byte_pos = '0;
                r.action = ACT_RX;
                seq_ph = PH_DATA;
              end
              PH_DATA: begin
                if (byte_pos < FRAME_LEN) frame_buf[byte_pos] = rx;
                byte_pos = byte_pos + 4'd1;
                if (byte_pos < FRAME_LEN) begin
                  r.action = ACT_ACK;
                  seq_ph = PH_RXN;
                end else begin
                  r.action = ACT_NACK;
                  seq_ph = PH_LAST;
                end
              end
              PH_RXN: begin
                r.action = ACT_RX;
                seq_ph = PH_DATA;
              end
              default: begin
                in_session = 1'b0;
                r.action = ACT_RELEASE;
                r.done = 1'b1;
                for (int k = 0; k < 7; k++) w[k] = {frame_buf[2*k], frame_buf[2*k+1]};
                v[0] = widen(w[1], 1'b1);
                v[1] = widen(w[0], 1'b1);
                v[2] = widen(w[2], 1'b1);
                v[3] = widen(w[3], 1'b0);
                v[4] = widen(w[5], 1'b1);
                v[5] = widen(w[4], 1'b1);
                v[6] = widen(w[6], 1'b1);
                read_frames = read_frames + 16'd1;
                for (int k = 0; k < 7; k++) begin
                  ch_sum[k] = (sum_frames == 16'd0) ? v[k] : ch_sum[k] + v[k];
                end
                sum_frames = sum_frames + 16'd1;
              end
            endcase
          end
        end
      end
      CMD_CLEAR: sum_frames = '0;
      default: ;
    endcase
    r.sums = ch_sum;
    r.acc = sum_frames;
    r.tot = read_frames;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (n_err < 40) begin
      $display("ERROR out beat %0d %s: got %h, expected %h", n_beats_out, field, got, want);
    end
    n_err++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_outputs.size());
      $display("i2c_imu_burst_read_accumulator_core: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left = rand_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred_r = predict_bus_step(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[12:5]);
        if (pin_on) begin
          pred_r.action = pin_act;
          pred_r.tx = pin_tx;
        end
        if (pred_r.done) n_frames++;
        if (pred_r.action == ACT_RELEASE && !pred_r.done) n_aborts++;
        due_outputs.push_back(pred_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.action = bus_action_e'(m_axis_tuser[2:0]);
        got_r.done = m_axis_tuser[3];
        got_r.tx = m_axis_tdata[7:0];
        for (int i = 0; i < 7; i++) got_r.sums[i] = m_axis_tdata[8 + 32*i +: 32];
        got_r.acc = m_axis_tdata[247:232];
        got_r.tot = m_axis_tdata[263:248];
        if (due_outputs.size() == 0) begin
          report_mismatch("unexpected beat", 32'(got_r.action), 32'(ACT_NONE));
        end else begin
          want_r = due_outputs.pop_front();
          if (got_r.action !== want_r.action)
            report_mismatch("bus_action", 32'(got_r.action), 32'(want_r.action));
          if (got_r.tx !== want_r.tx) report_mismatch("tx_byte", 32'(got_r.tx), 32'(want_r.tx));
          if (got_r.done !== want_r.done)
            report_mismatch("frame_done", 32'(got_r.done), 32'(want_r.done));
          for (int i = 0; i < 7; i++) begin
            if (got_r.sums[i] !== want_r.sums[i])
              report_mismatch($sformatf("sum[%0d]", i), got_r.sums[i], want_r.sums[i]);
          end
          if (got_r.acc !== want_r.acc)
            report_mismatch("accumulated_frames", 32'(got_r.acc), 32'(want_r.acc));
          if (got_r.tot !== want_r.tot)
            report_mismatch("total_frames", 32'(got_r.tot), 32'(want_r.tot));
        end
        n_beats_out++;
      end
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [4:0] fl, logic [7:0] rx,
                           logic chk, bus_action_e act, logic [7:0] tx);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b000, rx, fl};
    pin_on <= chk;
    pin_act <= act;
    pin_tx <= tx;
    do @(posedge clk_i); while (!s_axis_tready);
    n_beats_in++;
    gap = calm ? 0 : rand_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic send_free(logic [1:0] cmd, logic [4:0] fl, logic [7:0] rx);
    send_beat(cmd, fl, rx, 1'b0, ACT_NONE, 8'h00);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_device_address(logic [7:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dev_addr = value;
    n_cfg++;
  endtask

  // One burst read: a trigger and the 33 bus events of a full frame, with a
  // small chance of a bus error on any event and a few stray beats mixed in.
  task automatic run_session();
    logic [4:0] fl;
    send_free(CMD_TRIGGER, {4'($urandom), 1'b1}, 8'($urandom));
    for (int i = 0; i < 33; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_free(($urandom_range(0, 1) != 0) ? CMD_TRIGGER : CMD_CLEAR, 5'($urandom),
                  8'($urandom));
      end
      if ($urandom_range(0, 99) == 0) begin
        fl = {4'($urandom_range(1, 15)), 1'($urandom)};
        send_free(CMD_BUS_DONE, fl, rand_byte());
        return;
      end
      send_free(CMD_BUS_DONE, {4'b0000, 1'($urandom)}, rand_byte());
    end
  endtask

  initial begin
    int unsigned stop_at;
    logic [7:0] addr_plan [6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_TRIGGER;
    m_axis_tready = 1'b0;
    pin_on = 1'b0;
    pin_act = ACT_NONE;
    pin_tx = '0;
    for (int i = 0; i < 14; i++) frame_buf[i] = '0;

    dir_tab[0]  = '{CMD_BUS_DONE, F_ERR,           8'hFF, 1'b1, ACT_NONE,    8'h00};
    dir_tab[1]  = '{CMD_TRIGGER,  F_NONE,          8'h00, 1'b1, ACT_NONE,    8'h00};
    dir_tab[2]  = '{CMD_UNUSED,   F_ERR | F_FREE,  8'hFF, 1'b1, ACT_NONE,    8'h00};
    dir_tab[3]  = '{CMD_CLEAR,    F_ERR | F_FREE,  8'hFF, 1'b1, ACT_NONE,    8'h00};
    dir_tab[4]  = '{CMD_TRIGGER,  F_FREE,          8'h00, 1'b1, ACT_START,   8'h00};
    dir_tab[5]  = '{CMD_TRIGGER,  F_FREE,          8'h00, 1'b1, ACT_NONE,    8'h00};
    dir_tab[6]  = '{CMD_BUS_DONE, F_NONE,          8'hFF, 1'b1, ACT_TX,      8'hD0};
    dir_tab[7]  = '{CMD_BUS_DONE, F_NACK,          8'h00, 1'b1, ACT_RELEASE, 8'h00};
    dir_tab[8]  = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_NONE,    8'h00};
    dir_tab[9]  = '{CMD_TRIGGER,  F_ERR | F_FREE,  8'h00, 1'b1, ACT_START,   8'h00};
    dir_tab[10] = '{CMD_BUS_DONE, F_FREE,          8'h00, 1'b1, ACT_TX,      8'hD0};
    dir_tab[11] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_TX,      8'h3B};
    dir_tab[12] = '{CMD_BUS_DONE, F_BCOL,          8'h00, 1'b1, ACT_RELEASE, 8'h00};
    dir_tab[13] = '{CMD_TRIGGER,  F_FREE,          8'h00, 1'b1, ACT_START,   8'h00};
    dir_tab[14] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_TX,      8'hD0};
    dir_tab[15] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_TX,      8'h3B};
    dir_tab[16] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_RSTART,  8'h00};
    dir_tab[17] = '{CMD_BUS_DONE, F_WCOL,          8'h00, 1'b1, ACT_RELEASE, 8'h00};
    dir_tab[18] = '{CMD_TRIGGER,  F_FREE,          8'h00, 1'b1, ACT_START,   8'h00};
    dir_tab[19] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_TX,      8'hD0};
    dir_tab[20] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_TX,      8'h3B};
    dir_tab[21] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_RSTART,  8'h00};
    dir_tab[22] = '{CMD_BUS_DONE, F_NONE,          8'h00, 1'b1, ACT_TX,      8'hD1};
    dir_tab[23] = '{CMD_BUS_DONE, F_NONE,          8'hFF, 1'b0, ACT_NONE,    8'h00};
    dir_tab[24] = '{CMD_BUS_DONE, F_OVF,           8'hAA, 1'b1, ACT_RELEASE, 8'h00};
    dir_tab[25] = '{CMD_CLEAR,    F_NONE,          8'h00, 1'b1, ACT_NONE,    8'h00};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].cmd, dir_tab[i].fl, dir_tab[i].rx, dir_tab[i].chk,
                dir_tab[i].act, dir_tab[i].tx);
    end

    addr_plan[0] = 8'h00;
    addr_plan[1] = 8'hFF;
    addr_plan[2] = 8'($urandom);
    addr_plan[3] = 8'h01;
    addr_plan[4] = 8'($urandom);
    addr_plan[5] = 8'hFE;
    for (int p = 0; p < 6; p++) begin
      set_device_address(addr_plan[p]);
      calm = (p == 2);
      stop_at = n_beats_in + PHASE_BEATS;
      while (n_beats_in < stop_at) begin
        if ($urandom_range(0, 99) < 80) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 5)) begin
            send_free(2'($urandom_range(0, 3)), 5'($urandom), 8'($urandom));
          end
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(negedge clk_i);
    $display("covered %0d input beats, %0d output beats, %0d frames, %0d aborted sessions",
             n_beats_in, n_beats_out, n_frames, n_aborts);
    $display("device address settings written: %0d, errors: %0d", n_cfg, n_err);
    if (n_err == 0) begin
      $display("i2c_imu_burst_read_accumulator_core: match");
    end else begin
      $display("i2c_imu_burst_read_accumulator_core: mismatch");
    end
    $finish;
  end

endmodule

@@ i2c_imu_burst_read_accumulator_core.f @@
src/imu_acc_pkg.sv
src/imu_acc_front.sv
src/imu_acc_queue.sv
src/imu_acc_back.sv
src/i2c_imu_burst_read_accumulator_core.sv
dv/tb_top.sv
